[sv/dicg_pkg.sv]
// Shared widths, bit positions and command codes for the disk interface control glue.
package dicg_pkg;

   localparam int CmdWidth   = 2;
   localparam int DataWidth  = 8;
   localparam int DriveWidth = 2;
   localparam int LineCmdWidth = 2;

   // Input command codes.
   localparam logic [CmdWidth-1:0] CMD_CTRL_WRITE  = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_INTR_CHANGE = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_DRQ_CHANGE  = 2'd2;

   // Halt line commands.
   localparam logic [LineCmdWidth-1:0] HALT_NONE    = 2'd0;
   localparam logic [LineCmdWidth-1:0] HALT_RELEASE = 2'd1;
   localparam logic [LineCmdWidth-1:0] HALT_ASSERT  = 2'd2;

   // NMI line commands.
   localparam logic [LineCmdWidth-1:0] NMI_NONE   = 2'd0;
   localparam logic [LineCmdWidth-1:0] NMI_CLEAR  = 2'd1;
   localparam logic [LineCmdWidth-1:0] NMI_ASSERT = 2'd2;

   // Control byte bit positions.
   localparam int BIT_HALT_EN  = 7;
   localparam int BIT_DRIVE3   = 6;
   localparam int BIT_DENS_NMI = 5;
   localparam int BIT_DRIVE2   = 2;
   localparam int BIT_DRIVE1   = 1;
   localparam int BIT_DRIVE0   = 0;

   // Drive numbers.
   localparam logic [DriveWidth-1:0] DRIVE_0 = 2'd0;
   localparam logic [DriveWidth-1:0] DRIVE_1 = 2'd1;
   localparam logic [DriveWidth-1:0] DRIVE_2 = 2'd2;
   localparam logic [DriveWidth-1:0] DRIVE_3 = 2'd3;

   // Downstream delay before an asserted halt takes effect.
   localparam int HALT_DELAY_CYCLES = 7;

endpackage

[sv/dicg_req_if.sv]
// Request channel: control writes and controller line changes.
interface dicg_req_if
   import dicg_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CmdWidth-1:0]  cmd;
   logic [DataWidth-1:0] data;
   logic                 level;

   modport source (output valid, output cmd, output data, output level, input ready);
   modport sink   (input valid, input cmd, input data, input level, output ready);
endinterface

[sv/dicg_rsp_if.sv]
// Response channel: drive decode and halt/NMI line commands.
interface dicg_rsp_if
   import dicg_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [DriveWidth-1:0]   drive_sel;
   logic                    side_sel;
   logic                    double_density;
   logic [LineCmdWidth-1:0] halt_cmd;
   logic [LineCmdWidth-1:0] nmi_cmd;

   modport source (output valid, output drive_sel, output side_sel, output double_density,
                   output halt_cmd, output nmi_cmd, input ready);
   modport sink   (input valid, input drive_sel, input side_sel, input double_density,
                   input halt_cmd, input nmi_cmd, output ready);
endinterface

[sv/disk_interface_control_glue.sv]
// Top level of the disk interface control glue: input register, decode, result register.
//
//   channel   direction  word contents
//   req_ch    in         cmd, data, level
//   rsp_ch    out        drive_sel, side_sel, double_density, halt_cmd, nmi_cmd
//
// Each word passes through the input register and then the result register; one word is
// taken every cycle while the response side does not stall.
// The control byte and line levels update when a word moves into the result register.
// Synchronous reset clears the control byte and interrupt level and sets the data
// request level. A stalled response holds its word; the input register still takes one
// more word, and the request side stalls only when both registers are full.
module disk_interface_control_glue
   import dicg_pkg::*;
(
   input logic           clock,
   input logic           reset,
   dicg_req_if.sink      req_ch,
   dicg_rsp_if.source    rsp_ch
);

   // Input register.
   logic                 s1_valid_ff, s1_valid_in;
   logic [CmdWidth-1:0]  s1_cmd_ff;
   logic [DataWidth-1:0] s1_data_ff;
   logic                 s1_level_ff;

   // Block state.
   logic [DataWidth-1:0] ctrl_ff, ctrl_in;
   logic                 intr_ff, intr_in;
   logic                 drq_ff, drq_in;

   // Result register.
   logic                    out_valid_ff, out_valid_in;
   logic [DriveWidth-1:0]   drive_ff, drive_in;
   logic                    side_ff, side_in;
   logic                    dens_ff;
   logic [LineCmdWidth-1:0] halt_ff, halt_in;
   logic [LineCmdWidth-1:0] nmi_ff, nmi_in;

   logic req_take;
   logic out_load;

   assign out_load     = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || out_load;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   assign out_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      ctrl_in = ctrl_ff;
      intr_in = intr_ff;
      drq_in  = drq_ff;
      halt_in = HALT_NONE;
      nmi_in  = NMI_NONE;
      case (s1_cmd_ff)
         CMD_CTRL_WRITE: begin
            ctrl_in = s1_data_ff;
            halt_in = (s1_data_ff[BIT_HALT_EN] && !drq_ff) ? HALT_ASSERT : HALT_RELEASE;
            // A pending interrupt with NMI enabled releases halt and wins over an assert.
            if (s1_data_ff[BIT_DENS_NMI] && intr_ff) begin
               ctrl_in[BIT_HALT_EN] = 1'b0;
               halt_in = HALT_RELEASE;
               nmi_in  = NMI_ASSERT;
            end else begin
               nmi_in = NMI_CLEAR;
            end
         end
         CMD_INTR_CHANGE: begin
            intr_in = s1_level_ff;
            if (!s1_level_ff) begin
               nmi_in = NMI_CLEAR;
            end else begin
               ctrl_in[BIT_HALT_EN] = 1'b0;
               halt_in = HALT_RELEASE;
               nmi_in  = ctrl_ff[BIT_DENS_NMI] ? NMI_ASSERT : NMI_CLEAR;
            end
         end
         CMD_DRQ_CHANGE: begin
            drq_in = s1_level_ff;
            if (!s1_level_ff && ctrl_ff[BIT_HALT_EN]) begin
               halt_in = HALT_ASSERT;
            end else begin
               halt_in = HALT_RELEASE;
            end
         end
         default: begin
         end
      endcase
   end

   // Drive decode from the updated control byte, drive bits tested 2, 1, 0, then 3.
   always_comb begin
      if (ctrl_in[BIT_DRIVE2]) begin
         drive_in = DRIVE_2;
      end else if (ctrl_in[BIT_DRIVE1]) begin
         drive_in = DRIVE_1;
      end else if (ctrl_in[BIT_DRIVE0]) begin
         drive_in = DRIVE_0;
      end else if (ctrl_in[BIT_DRIVE3]) begin
         drive_in = DRIVE_3;
      end else begin
         drive_in = DRIVE_0;
      end
      side_in = ctrl_in[BIT_DRIVE3] && (drive_in != DRIVE_3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         intr_ff      <= 1'b0;
         drq_ff       <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            ctrl_ff <= ctrl_in;
            intr_ff <= intr_in;
            drq_ff  <= drq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff   <= req_ch.cmd;
         s1_data_ff  <= req_ch.data;
         s1_level_ff <= req_ch.level;
      end
      if (out_load) begin
         drive_ff <= drive_in;
         side_ff  <= side_in;
         dens_ff  <= ctrl_in[BIT_DENS_NMI];
         halt_ff  <= halt_in;
         nmi_ff   <= nmi_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.drive_sel      = drive_ff;
   assign rsp_ch.side_sel       = side_ff;
   assign rsp_ch.double_density = dens_ff;
   assign rsp_ch.halt_cmd       = halt_ff;
   assign rsp_ch.nmi_cmd        = nmi_ff;

   // An asserted interrupt line always leaves halt disabled in the control byte.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && s1_cmd_ff == CMD_INTR_CHANGE && s1_level_ff) |=> !ctrl_ff[BIT_HALT_EN])
      else $error("halt enable survived an interrupt");

   // NMI is only raised with NMI enabled, and it always comes with a halt release.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.nmi_cmd == NMI_ASSERT) |->
         (rsp_ch.double_density && rsp_ch.halt_cmd == HALT_RELEASE))
      else $error("NMI assert without enable or halt release");

   // Side 1 never goes with drive 3.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.side_sel) |-> (rsp_ch.drive_sel != DRIVE_3))
      else $error("side select on drive 3");

   // A word held in the input register is never dropped while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> s1_valid_ff)
      else $error("input word lost");

endmodule
